// File: rtl/core/afu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Activation function unit package
// Shared types, opcodes, the sigmoid table and fixed-point helpers.
// ----------------------------------------------------------------------------
package afu_pkg;

    localparam int DATA_W      = 16;
    localparam int FRAC_BITS   = 12;
    localparam int TAB_ENTRIES = 256;
    localparam int TAB_BITS    = $clog2(TAB_ENTRIES);
    localparam int EXT_W       = DATA_W + 1;
    localparam int PROD_W      = 2 * EXT_W;

    localparam logic [3:0] OP_RELU_FWD  = 4'd0;
    localparam logic [3:0] OP_RELU_BWD  = 4'd1;
    localparam logic [3:0] OP_SIG_FWD   = 4'd2;
    localparam logic [3:0] OP_SIG_BWD   = 4'd3;
    localparam logic [3:0] OP_SIG_RBWD  = 4'd4;
    localparam logic [3:0] OP_SIG_BWD2  = 4'd5;
    localparam logic [3:0] OP_TANH_FWD  = 4'd6;
    localparam logic [3:0] OP_TANH_BWD  = 4'd7;
    localparam logic [3:0] OP_TANH_RBWD = 4'd8;

    localparam logic signed [EXT_W-1:0] ONE = EXT_W'(1) <<< FRAC_BITS;
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    typedef struct packed {
        logic [3:0]               opcode;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] grad_in;
        logic signed [DATA_W-1:0] tangent_x;
        logic signed [DATA_W-1:0] second_grad;
        logic signed [DATA_W-1:0] accum_in;
        logic                     last_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     last_out;
    } t_out;

    typedef struct packed {
        logic [3:0]               op;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] dy;
        logic signed [DATA_W-1:0] rx;
        logic signed [DATA_W-1:0] g2;
        logic signed [DATA_W-1:0] acc;
        logic                     last;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] t;
    } t_mid;

    typedef struct packed {
        t_mid                     m;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] s2;
        logic signed [DATA_W-1:0] p1;
        logic signed [EXT_W-1:0]  k2;
        logic signed [DATA_W-1:0] prod;
        logic signed [DATA_W-1:0] mres;
    } t_stage;

    typedef logic [FRAC_BITS:0] t_sig_tab [0:TAB_ENTRIES];

    // Long division by shift and subtract, used only while the table is built.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned rm;
        q  = '0;
        rm = '0;
        for (int b = 63; b >= 0; b--) begin
            rm = {rm[62:0], num[b]};
            if (rm >= den) begin
                rm   = rm - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint exp_neg(input longint n, input longint f);
        longint e;
        longint term;
        longint series;
        longint unsigned p;
        e = longint'(1) << 30;
        term = longint'(1) << 30;
        series = term;
        if (n > 30) begin
            return 0;
        end
        for (longint j = 0; j < n; j++) begin
            e = (e * 64'sd395007542) >>> 30;
        end
        for (int i = 1; i <= 16; i++) begin
            p = longint'(term) * f;
            term = longint'(udiv(p >> 30, longint'(i)));
            if ((i & 1) == 1) begin
                series = series - term;
            end else begin
                series = series + term;
            end
        end
        return (e * series) >>> 30;
    endfunction

    function automatic t_sig_tab build_sig_tab();
        t_sig_tab tab;
        longint scaled;
        longint n;
        longint r;
        longint f;
        longint e;
        longint d;
        for (int k = 0; k <= TAB_ENTRIES; k++) begin
            scaled = longint'(k) << (DATA_W - FRAC_BITS);
            n = scaled >>> TAB_BITS;
            r = scaled & longint'(TAB_ENTRIES - 1);
            f = (r << 30) >>> TAB_BITS;
            e = exp_neg(n, f);
            d = (longint'(1) << 30) + ((e < 0) ? 0 : e);
            tab[k] = (FRAC_BITS + 1)'(udiv((longint'(1) << (FRAC_BITS + 30)) + (d >>> 1),
                                           d));
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig_tab();

    function automatic logic [FRAC_BITS:0] sig_mag(input logic [EXT_W-1:0] mag);
        logic [EXT_W+TAB_BITS-1:0]      num;
        logic [EXT_W+TAB_BITS-DATA_W-1:0] idx;
        logic [DATA_W-1:0]              rem;
        logic [FRAC_BITS:0]             lo;
        logic [FRAC_BITS:0]             diff;
        logic [FRAC_BITS+DATA_W+1:0]    prod;
        num = {mag, TAB_BITS'(0)};
        idx = num[EXT_W+TAB_BITS-1:DATA_W];
        rem = num[DATA_W-1:0];
        if (idx >= TAB_ENTRIES) begin
            return SIG_TAB[TAB_ENTRIES];
        end
        lo = SIG_TAB[idx[TAB_BITS:0]];
        diff = SIG_TAB[idx[TAB_BITS:0] + 1'b1] - lo;
        prod = (FRAC_BITS + DATA_W + 2)'(diff) * (FRAC_BITS + DATA_W + 2)'(rem);
        return lo + (FRAC_BITS + 1)'(prod >> DATA_W);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [PROD_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] mulq(input logic signed [EXT_W-1:0] a,
                                                      input logic signed [EXT_W-1:0] b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return sat(p >>> FRAC_BITS);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/afu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Activation front end
// Accepts words and looks up sigmoid of x and of 2x for the back end.
// ----------------------------------------------------------------------------
module afu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire afu_pkg::t_in i_in,
    output logic              o_full,
    output logic              o_valid,
    output afu_pkg::t_mid     o_mid,
    input  wire logic         i_ready
);
    logic                r_valid;
    afu_pkg::t_mid       r_mid;
    afu_pkg::t_mid       n_mid;
    logic                load;
    logic signed [afu_pkg::EXT_W-1:0] xe;
    logic [afu_pkg::EXT_W-1:0]        mag1;
    logic [afu_pkg::EXT_W-1:0]        mag2;
    logic signed [afu_pkg::EXT_W-1:0] s1;
    logic signed [afu_pkg::EXT_W-1:0] s2;
    logic signed [afu_pkg::EXT_W-1:0] sy;
    logic signed [afu_pkg::EXT_W-1:0] st;

    assign o_full  = r_valid && !i_ready;
    assign load    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_mid   = r_mid;

    always_comb begin
        xe   = afu_pkg::EXT_W'(i_in.x_value);
        mag1 = (xe < 0) ? afu_pkg::EXT_W'(-xe) : afu_pkg::EXT_W'(xe);
        mag2 = {mag1[afu_pkg::EXT_W-2:0], 1'b0};
        s1   = afu_pkg::EXT_W'(afu_pkg::sig_mag(mag1));
        s2   = afu_pkg::EXT_W'(afu_pkg::sig_mag(mag2));
        sy   = (xe < 0) ? afu_pkg::ONE - s1 : s1;
        st   = (xe < 0) ? afu_pkg::ONE - s2 : s2;
        n_mid.op   = i_in.opcode;
        n_mid.x    = i_in.x_value;
        n_mid.dy   = i_in.grad_in;
        n_mid.rx   = i_in.tangent_x;
        n_mid.g2   = i_in.second_grad;
        n_mid.acc  = i_in.accum_in;
        n_mid.last = i_in.last_in;
        n_mid.y    = sy[afu_pkg::DATA_W-1:0];
        n_mid.t    = afu_pkg::DATA_W'((st <<< 1) - afu_pkg::ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_push;
        end
        if (load && i_push) begin
            r_mid <= n_mid;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/afu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Activation decoupling queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module afu_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire afu_pkg::t_mid i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output afu_pkg::t_mid      o_data
);
    afu_pkg::t_mid r_mem [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp)) else $error("pointer mismatch");
    a_ptr_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp)) else $error("pointer mismatch at one word");
`endif
endmodule
`default_nettype wire

// File: rtl/core/afu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Activation back end
// Four-stage multiply pipeline that forms the selected result word.
// ----------------------------------------------------------------------------
module afu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire afu_pkg::t_mid i_mid,
    output logic               o_take,
    output logic               o_empty,
    input  wire logic          i_pop,
    output afu_pkg::t_out      o_out
);
    logic             en;
    logic [2:0]       r_v;
    logic             r_ov;
    afu_pkg::t_stage  r_s1, r_s2, r_s3;
    afu_pkg::t_stage  n_s1, n_s2, n_s3;
    afu_pkg::t_out    r_out;
    afu_pkg::t_out    n_out;
    logic signed [afu_pkg::EXT_W-1:0] y_e;
    logic signed [afu_pkg::EXT_W-1:0] t_e;
    logic signed [afu_pkg::EXT_W-1:0] om2y;
    logic signed [afu_pkg::EXT_W-1:0] ma;
    logic signed [afu_pkg::EXT_W-1:0] mb;
    logic signed [afu_pkg::DATA_W-1:0] g;
    logic signed [afu_pkg::DATA_W-1:0] sum;

    assign en      = !r_ov || i_pop;
    assign o_take  = en && i_valid;
    assign o_empty = !r_ov;
    assign o_out   = r_out;

    always_comb begin
        y_e  = afu_pkg::EXT_W'(i_mid.y);
        t_e  = afu_pkg::EXT_W'(i_mid.t);
        om2y = afu_pkg::ONE - (y_e <<< 1);
        n_s1      = '0;
        n_s1.m    = i_mid;
        n_s1.d    = afu_pkg::mulq(y_e, afu_pkg::ONE - y_e);
        n_s1.s2   = afu_pkg::DATA_W'(afu_pkg::ONE - afu_pkg::EXT_W'(afu_pkg::mulq(t_e, t_e)));
        n_s1.p1   = (i_mid.op == afu_pkg::OP_SIG_BWD2)
                  ? afu_pkg::mulq(afu_pkg::EXT_W'(i_mid.dy), om2y)
                  : afu_pkg::mulq(afu_pkg::EXT_W'(i_mid.dy), afu_pkg::EXT_W'(i_mid.rx));
        n_s1.k2   = (i_mid.op == afu_pkg::OP_TANH_RBWD) ? -(t_e <<< 1) : om2y;
    end

    always_comb begin
        n_s2 = r_s1;
        case (r_s1.m.op)
            afu_pkg::OP_SIG_RBWD, afu_pkg::OP_TANH_RBWD: begin
                ma = afu_pkg::EXT_W'(r_s1.p1);
                mb = r_s1.k2;
            end
            afu_pkg::OP_SIG_BWD2: begin
                ma = afu_pkg::EXT_W'(r_s1.m.g2);
                mb = afu_pkg::EXT_W'(r_s1.d);
            end
            afu_pkg::OP_SIG_BWD: begin
                ma = afu_pkg::EXT_W'(r_s1.m.dy);
                mb = afu_pkg::EXT_W'(r_s1.d);
            end
            afu_pkg::OP_TANH_BWD: begin
                ma = afu_pkg::EXT_W'(r_s1.m.dy);
                mb = afu_pkg::EXT_W'(r_s1.s2);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        n_s2.prod = afu_pkg::mulq(ma, mb);
    end

    always_comb begin
        n_s3 = r_s2;
        if (r_s2.m.op == afu_pkg::OP_SIG_BWD2) begin
            g = afu_pkg::sat(afu_pkg::PROD_W'(r_s2.prod) + afu_pkg::PROD_W'(r_s2.p1));
        end else begin
            g = afu_pkg::sat(afu_pkg::PROD_W'(r_s2.m.g2) + afu_pkg::PROD_W'(r_s2.prod));
        end
        case (r_s2.m.op)
            afu_pkg::OP_SIG_RBWD, afu_pkg::OP_SIG_BWD2: begin
                n_s3.mres = afu_pkg::mulq(afu_pkg::EXT_W'(g), afu_pkg::EXT_W'(r_s2.d));
            end
            afu_pkg::OP_TANH_RBWD: begin
                n_s3.mres = afu_pkg::mulq(afu_pkg::EXT_W'(g), afu_pkg::EXT_W'(r_s2.s2));
            end
            default: begin
                n_s3.mres = r_s2.prod;
            end
        endcase
    end

    always_comb begin
        sum = afu_pkg::sat(afu_pkg::PROD_W'(r_s3.m.acc) + afu_pkg::PROD_W'(r_s3.mres));
        n_out.last_out = r_s3.m.last;
        case (r_s3.m.op)
            afu_pkg::OP_RELU_FWD: begin
                n_out.result_value = (r_s3.m.x > 0) ? r_s3.m.x : '0;
            end
            afu_pkg::OP_RELU_BWD: begin
                n_out.result_value = afu_pkg::sat(afu_pkg::PROD_W'(r_s3.m.acc)
                    + ((r_s3.m.x > 0) ? afu_pkg::PROD_W'(r_s3.m.dy) : '0));
            end
            afu_pkg::OP_SIG_FWD: begin
                n_out.result_value = r_s3.m.y;
            end
            afu_pkg::OP_TANH_FWD: begin
                n_out.result_value = r_s3.m.t;
            end
            afu_pkg::OP_SIG_BWD, afu_pkg::OP_SIG_RBWD, afu_pkg::OP_SIG_BWD2,
            afu_pkg::OP_TANH_BWD, afu_pkg::OP_TANH_RBWD: begin
                n_out.result_value = sum;
            end
            default: begin
                n_out.result_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[1:0], i_valid};
            r_ov <= r_v[2];
        end
        if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_pop) |=> (r_ov && $stable(r_out))) else $error("result word lost");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v[2]) |=> r_ov) else $error("pipeline word dropped");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> !o_take) else $error("word taken while stalled");
`endif
endmodule
`default_nettype wire

// File: rtl/core/activation_function_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Activation function unit
// Elementwise ReLU, sigmoid and tanh forward and backward on Q4.12 words.
// ----------------------------------------------------------------------------
// A pushed word passes through the front-end register, the queue, back-end stages s1 to s3 and the output register.
// Throughput: one word per cycle while the output is not stalled, through the four-stage back-end multiply pipeline.
// A two-word queue lets the front end keep accepting while the output is stalled, until the queue is full.
// Reset is synchronous and active low; it empties the queue and all pipeline stages.
module activation_function_unit_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire afu_pkg::t_in  i_in,
    output logic               o_full,
    output logic               o_empty,
    input  wire logic          i_pop,
    output afu_pkg::t_out      o_out
);
    logic          f_valid;
    afu_pkg::t_mid f_mid;
    logic          q_full;
    logic          q_empty;
    afu_pkg::t_mid q_data;
    logic          b_take;

    afu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_in    (i_in),
        .o_full  (o_full),
        .o_valid (f_valid),
        .o_mid   (f_mid),
        .i_ready (!q_full)
    );

    afu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_mid),
        .o_full  (q_full),
        .i_pop   (b_take),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    afu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_mid   (q_data),
        .o_take  (b_take),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
